// File: design/i2c_seq_pkg.sv
`default_nettype none

package i2c_seq_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // Link status codes reported with every result.
   localparam logic [1:0] LINK_IDLE  = 2'd0;
   localparam logic [1:0] LINK_BUSY  = 2'd1;
   localparam logic [1:0] LINK_READY = 2'd2;
   localparam logic [1:0] LINK_ERROR = 2'd3;

   // Direction bit that replaces bit 0 of the address byte.
   localparam logic DIR_WRITE = 1'b0;
   localparam logic DIR_READ  = 1'b1;

   // Control for the transmit buffer, one set per accepted beat.
   typedef struct packed {
      logic       load;
      logic [7:0] load_byte;
      logic       clear;
      logic       advance;
   } tx_ctl_type;

endpackage

`default_nettype wire

// File: design/i2c_seq_tx_buffer.sv
`default_nettype none

module i2c_seq_tx_buffer #(
   parameter int TX_DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire i2c_seq_pkg::tx_ctl_type ctl,
   output logic [7:0]                  head_byte
);
   import i2c_seq_pkg::*;

   localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TX_DEPTH - 1);

   logic [PTR_W-1:0] load_ptr_ff;
   logic [PTR_W-1:0] load_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [7:0]       store [TX_DEPTH];
   logic [7:0]       head_ff;

   // Both pointers wrap at the buffer depth; a start accepted while the link is not busy clears them.
   always_comb begin
      load_ptr_in = load_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      if (ctl.clear) begin
         load_ptr_in = '0;
         wr_ptr_in   = '0;
      end else begin
         if (ctl.load) begin
            load_ptr_in = (load_ptr_ff == LAST_PTR) ? '0 : load_ptr_ff + 1'b1;
         end
         if (ctl.advance) begin
            wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         wr_ptr_ff   <= '0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
      end
   end

   // The store is read one beat ahead, so the byte at the send pointer is
   // always waiting in a register. A load to that same entry is forwarded.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         store[load_ptr_ff] <= ctl.load_byte;
      end
      if (ctl.load && (load_ptr_ff == wr_ptr_in)) begin
         head_ff <= ctl.load_byte;
      end else begin
         head_ff <= store[wr_ptr_in];
      end
   end

   assign head_byte = head_ff;

endmodule

`default_nettype wire

// File: design/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer.
// The request channel carries three kinds of beats: a byte to load into the
// transmit buffer, a start beat that arms one transaction (address, write
// count, read count), and a bus event beat with the start, stop, NACK and
// buffer-full flags plus the received byte. Every request beat produces
// exactly one response beat with the bus commands for that step (byte to
// send, repeated start, stop, receive enable, ACK or NACK), any received
// byte, and the link status after the step.
// The response for an accepted beat is registered and presented in the next
// cycle. A new beat can be accepted every cycle while req_stall is low; the rate
// is set by the single decision stage between the request and the response
// register, and the transmit buffer is read one beat ahead to keep pace.
// When the receiver stalls, the response register holds its beat and
// req_stall is raised until that beat is taken.
// Reset clears the link to idle, the phase to the start phase, all counters
// and buffer pointers, and empties the response register. Transmit buffer
// contents are not cleared.
`default_nettype none

module i2c_master_transaction_sequencer #(
   parameter int TX_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic [7:0] req_slave_address,
   input  wire logic [4:0] req_write_count,
   input  wire logic [7:0] req_read_count,
   input  wire logic       req_start_seen,
   input  wire logic       req_stop_seen,
   input  wire logic       req_nack_seen,
   input  wire logic       req_buffer_full,
   input  wire logic [7:0] req_received_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_send_valid,
   output logic [7:0]      rsp_send_byte,
   output logic            rsp_repeat_start,
   output logic            rsp_stop_request,
   output logic            rsp_receive_enable,
   output logic            rsp_ack_send,
   output logic            rsp_ack_is_nack,
   output logic            rsp_rx_valid,
   output logic [7:0]      rsp_rx_byte,
   output logic [1:0]      rsp_link_status
);
   import i2c_seq_pkg::*;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_RESTART = 3'd1,
      PH_TX      = 3'd2,
      PH_RX_PRE  = 3'd3,
      PH_RX      = 3'd4,
      PH_RX_END  = 3'd5,
      PH_STOP    = 3'd6
   } phase_type;

   logic       accept;
   logic [7:0] head_byte;
   tx_ctl_type tx_ctl_raw;
   tx_ctl_type tx_ctl;

   // Transaction state.
   logic [1:0] link_ff, link_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] addr_ff, addr_in;
   logic [4:0] writes_ff, writes_in;
   logic [7:0] reads_ff, reads_in;

   // Response register.
   logic       rsp_valid_ff;
   logic       send_valid_ff, send_valid_in;
   logic [7:0] send_byte_ff, send_byte_in;
   logic       repeat_start_ff, repeat_start_in;
   logic       stop_request_ff, stop_request_in;
   logic       receive_enable_ff, receive_enable_in;
   logic       ack_send_ff, ack_send_in;
   logic       ack_is_nack_ff, ack_is_nack_in;
   logic       rx_valid_ff, rx_valid_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       do_rx;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Decision logic for one beat.
   always_comb begin
      link_in           = link_ff;
      phase_in          = phase_ff;
      addr_in           = addr_ff;
      writes_in         = writes_ff;
      reads_in          = reads_ff;
      send_valid_in     = 1'b0;
      send_byte_in      = 8'd0;
      repeat_start_in   = 1'b0;
      stop_request_in   = 1'b0;
      receive_enable_in = 1'b0;
      ack_send_in       = 1'b0;
      ack_is_nack_in    = 1'b0;
      rx_valid_in       = 1'b0;
      rx_byte_in        = 8'd0;
      do_rx             = 1'b0;
      tx_ctl_raw        = '0;
      tx_ctl_raw.load_byte = req_tx_byte;

      case (req_kind)
         KIND_LOAD: begin
            tx_ctl_raw.load = 1'b1;
         end
         KIND_START: begin
            if (link_ff != LINK_BUSY) begin
               addr_in          = req_slave_address;
               writes_in        = req_write_count;
               reads_in         = req_read_count;
               phase_in         = PH_START;
               link_in          = LINK_BUSY;
               tx_ctl_raw.clear = 1'b1;
            end
         end
         KIND_EVENT: begin
            if (link_ff == LINK_BUSY) begin
               case (phase_ff)
                  PH_START: begin
                     if (!req_start_seen) begin
                        link_in = LINK_ERROR;
                     end else if (writes_ff != 5'd0) begin
                        send_valid_in = 1'b1;
                        send_byte_in  = {addr_ff[7:1], DIR_WRITE};
                        phase_in      = PH_TX;
                     end else if (reads_ff != 8'd0) begin
                        send_valid_in = 1'b1;
                        send_byte_in  = {addr_ff[7:1], DIR_READ};
                        phase_in      = PH_RX_PRE;
                     end else begin
                        link_in = LINK_ERROR;
                     end
                  end
                  PH_RESTART: begin
                     if (!req_start_seen) begin
                        link_in = LINK_ERROR;
                     end else if (reads_ff != 8'd0) begin
                        send_valid_in = 1'b1;
                        send_byte_in  = {addr_ff[7:1], DIR_READ};
                        phase_in      = PH_RX_PRE;
                     end else begin
                        link_in = LINK_ERROR;
                     end
                  end
                  PH_TX: begin
                     if (req_nack_seen) begin
                        link_in = LINK_ERROR;
                     end else if (writes_ff != 5'd0) begin
                        send_valid_in      = 1'b1;
                        send_byte_in       = head_byte;
                        tx_ctl_raw.advance = 1'b1;
                        writes_in          = writes_ff - 5'd1;
                     end else if (reads_ff != 8'd0) begin
                        repeat_start_in = 1'b1;
                        phase_in        = PH_RESTART;
                     end else begin
                        stop_request_in = 1'b1;
                        phase_in        = PH_STOP;
                     end
                  end
                  PH_RX_PRE: begin
                     // After the address ACK the same event runs the receive step.
                     if (req_nack_seen) begin
                        link_in = LINK_ERROR;
                     end else begin
                        phase_in          = PH_RX;
                        receive_enable_in = 1'b1;
                        do_rx             = 1'b1;
                     end
                  end
                  PH_RX: begin
                     do_rx = 1'b1;
                  end
                  PH_RX_END: begin
                     stop_request_in = 1'b1;
                     phase_in        = PH_STOP;
                  end
                  PH_STOP: begin
                     link_in = req_stop_seen ? LINK_READY : LINK_ERROR;
                  end
                  default: begin
                  end
               endcase

               // Receive step: wait for a byte, then ACK it or NACK the last one.
               if (do_rx) begin
                  if (!req_buffer_full) begin
                     receive_enable_in = 1'b1;
                  end else begin
                     ack_send_in = 1'b1;
                     rx_valid_in = 1'b1;
                     rx_byte_in  = req_received_byte;
                     if (reads_ff > 8'd1) begin
                        reads_in = reads_ff - 8'd1;
                     end else begin
                        ack_is_nack_in = 1'b1;
                        phase_in       = PH_RX_END;
                        if (reads_ff != 8'd0) begin
                           reads_in = reads_ff - 8'd1;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign tx_ctl = accept ? tx_ctl_raw : '0;

   i2c_seq_tx_buffer #(
      .TX_DEPTH(TX_DEPTH)
   ) u_tx_buffer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tx_ctl),
      .head_byte (head_byte)
   );

   // State and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= LINK_IDLE;
         phase_ff     <= PH_START;
         addr_ff      <= 8'd0;
         writes_ff    <= 5'd0;
         reads_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            link_ff      <= link_in;
            phase_ff     <= phase_in;
            addr_ff      <= addr_in;
            writes_ff    <= writes_in;
            reads_ff     <= reads_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         send_valid_ff     <= send_valid_in;
         send_byte_ff      <= send_byte_in;
         repeat_start_ff   <= repeat_start_in;
         stop_request_ff   <= stop_request_in;
         receive_enable_ff <= receive_enable_in;
         ack_send_ff       <= ack_send_in;
         ack_is_nack_ff    <= ack_is_nack_in;
         rx_valid_ff       <= rx_valid_in;
         rx_byte_ff        <= rx_byte_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_valid     = send_valid_ff;
   assign rsp_send_byte      = send_byte_ff;
   assign rsp_repeat_start   = repeat_start_ff;
   assign rsp_stop_request   = stop_request_ff;
   assign rsp_receive_enable = receive_enable_ff;
   assign rsp_ack_send       = ack_send_ff;
   assign rsp_ack_is_nack    = ack_is_nack_ff;
   assign rsp_rx_valid       = rx_valid_ff;
   assign rsp_rx_byte        = rx_byte_ff;
   assign rsp_link_status    = link_ff;

   // The response register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted beat shows up as a response in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no response");

   // A held response must block new requests.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request accepted while response stalled");

   // Any bus command leaves the link busy.
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_send_valid || rsp_repeat_start || rsp_stop_request ||
                     rsp_receive_enable || rsp_ack_send))
      |-> (rsp_link_status == LINK_BUSY))
      else $error("bus command with link not busy");

   // A received byte is always acknowledged in the same step.
   a_rx_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_rx_valid == rsp_ack_send) &&
                     (!rsp_ack_is_nack || rsp_ack_send)))
      else $error("received byte and acknowledge out of step");

endmodule

`default_nettype wire

// File: verif/i2c_master_transaction_sequencer_test.sv
`default_nettype none

module i2c_master_transaction_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import i2c_seq_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int ITEM_TARGET = 1600;
   localparam int CYCLE_LIMIT = 1_000_000;

   // Phases of the transfer sequence as the testbench tracks them.
   typedef enum logic [2:0] {
      SEQ_START,
      SEQ_RESTART,
      SEQ_WRITE,
      SEQ_ADDR_ACK,
      SEQ_RECEIVE,
      SEQ_RX_DONE,
      SEQ_STOP_CHECK
   } seq_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic [7:0] slave_address;
      logic [4:0] write_count;
      logic [7:0] read_count;
      logic       start_seen;
      logic       stop_seen;
      logic       nack_seen;
      logic       buffer_full;
      logic [7:0] received_byte;
   } bus_req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       repeat_start;
      logic       stop_request;
      logic       receive_enable;
      logic       ack_send;
      logic       ack_is_nack;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [1:0] link_status;
   } bus_cmd_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_LOAD;
   logic [7:0] req_tx_byte = '0;
   logic [7:0] req_slave_address = '0;
   logic [4:0] req_write_count = '0;
   logic [7:0] req_read_count = '0;
   logic       req_start_seen = 1'b0;
   logic       req_stop_seen = 1'b0;
   logic       req_nack_seen = 1'b0;
   logic       req_buffer_full = 1'b0;
   logic [7:0] req_received_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_send_valid;
   logic [7:0] rsp_send_byte;
   logic       rsp_repeat_start;
   logic       rsp_stop_request;
   logic       rsp_receive_enable;
   logic       rsp_ack_send;
   logic       rsp_ack_is_nack;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic [1:0] rsp_link_status;

   // Mirror of the sequencer state, updated for every accepted request beat.
   logic [1:0]    seq_link = LINK_IDLE;
   seq_phase_type seq_phase = SEQ_START;
   logic [7:0]    seq_address = '0;
   logic [4:0]    seq_writes_left = '0;
   logic [7:0]    seq_reads_left = '0;
   logic [3:0]    seq_wr_ptr = '0;
   logic [3:0]    seq_ld_ptr = '0;
   logic [7:0]    seq_tx_bytes [16];

   bus_cmd_type pending_commands [$];

   int  beats_sent = 0;
   int  responses_checked = 0;
   int  mismatch_count = 0;
   int  completed_transfers = 0;
   int  aborted_transfers = 0;
   int  rx_bytes_seen = 0;
   int  cycle_count = 0;
   int  rsp_hold_request = 0;
   int  stall_left = 0;
   int  free_left = 0;
   bit  sender_idles = 1'b1;

   i2c_master_transaction_sequencer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_tx_byte        (req_tx_byte),
      .req_slave_address  (req_slave_address),
      .req_write_count    (req_write_count),
      .req_read_count     (req_read_count),
      .req_start_seen     (req_start_seen),
      .req_stop_seen      (req_stop_seen),
      .req_nack_seen      (req_nack_seen),
      .req_buffer_full    (req_buffer_full),
      .req_received_byte  (req_received_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_byte      (rsp_send_byte),
      .rsp_repeat_start   (rsp_repeat_start),
      .rsp_stop_request   (rsp_stop_request),
      .rsp_receive_enable (rsp_receive_enable),
      .rsp_ack_send       (rsp_ack_send),
      .rsp_ack_is_nack    (rsp_ack_is_nack),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_link_status    (rsp_link_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_commands.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int random_idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // An abort drops the link into the error status, where bus events are ignored until the next start.
   function automatic void abort_transfer();
      seq_link = LINK_ERROR;
      aborted_transfers++;
   endfunction

   // Receive step: wait for a full buffer, then hand the byte out and ACK it,
   // or NACK it when it is the last one.
   function automatic void take_rx_byte(input bus_req_type b, inout bus_cmd_type c);
      if (!b.buffer_full) begin
         c.receive_enable = 1'b1;
      end else begin
         c.ack_send = 1'b1;
         c.rx_valid = 1'b1;
         c.rx_byte  = b.received_byte;
         rx_bytes_seen++;
         if (seq_reads_left > 8'd1) begin
            seq_reads_left = seq_reads_left - 8'd1;
         end else begin
            c.ack_is_nack = 1'b1;
            seq_phase = SEQ_RX_DONE;
            if (seq_reads_left != 8'd0) seq_reads_left = seq_reads_left - 8'd1;
         end
      end
   endfunction

   // Works out the bus commands for one request beat and advances the mirror.
   function automatic void predict_commands(input bus_req_type b, output bus_cmd_type c);
      c = '0;
      case (b.kind)
         KIND_LOAD: begin
            seq_tx_bytes[seq_ld_ptr] = b.tx_byte;
            seq_ld_ptr = seq_ld_ptr + 4'd1;
         end
         KIND_START: begin
            if (seq_link != LINK_BUSY) begin
               seq_address     = b.slave_address;
               seq_writes_left = b.write_count;
               seq_reads_left  = b.read_count;
               seq_wr_ptr      = '0;
               seq_ld_ptr      = '0;
               seq_phase       = SEQ_START;
               seq_link        = LINK_BUSY;
            end
         end
         KIND_EVENT: begin
            if (seq_link == LINK_BUSY) begin
               case (seq_phase)
                  SEQ_START: begin
                     if (!b.start_seen) begin
                        abort_transfer();
                     end else if (seq_writes_left != 5'd0) begin
                        c.send_valid = 1'b1;
                        c.send_byte  = {seq_address[7:1], DIR_WRITE};
                        seq_phase    = SEQ_WRITE;
                     end else if (seq_reads_left != 8'd0) begin
                        c.send_valid = 1'b1;
                        c.send_byte  = {seq_address[7:1], DIR_READ};
                        seq_phase    = SEQ_ADDR_ACK;
                     end else begin
                        abort_transfer();
                     end
                  end
                  SEQ_RESTART: begin
                     if (!b.start_seen || seq_reads_left == 8'd0) begin
                        abort_transfer();
                     end else begin
                        c.send_valid = 1'b1;
                        c.send_byte  = {seq_address[7:1], DIR_READ};
                        seq_phase    = SEQ_ADDR_ACK;
                     end
                  end
                  SEQ_WRITE: begin
                     if (b.nack_seen) begin
                        abort_transfer();
                     end else if (seq_writes_left != 5'd0) begin
                        c.send_valid    = 1'b1;
                        c.send_byte     = seq_tx_bytes[seq_wr_ptr];
                        seq_wr_ptr      = seq_wr_ptr + 4'd1;
                        seq_writes_left = seq_writes_left - 5'd1;
                     end else if (seq_reads_left != 8'd0) begin
                        c.repeat_start = 1'b1;
                        seq_phase      = SEQ_RESTART;
                     end else begin
                        c.stop_request = 1'b1;
                        seq_phase      = SEQ_STOP_CHECK;
                     end
                  end
                  SEQ_ADDR_ACK: begin
                     // After the address ACK the same beat runs the receive step.
                     if (b.nack_seen) begin
                        abort_transfer();
                     end else begin
                        seq_phase = SEQ_RECEIVE;
                        c.receive_enable = 1'b1;
                        take_rx_byte(b, c);
                     end
                  end
                  SEQ_RECEIVE: take_rx_byte(b, c);
                  SEQ_RX_DONE: begin
                     c.stop_request = 1'b1;
                     seq_phase      = SEQ_STOP_CHECK;
                  end
                  SEQ_STOP_CHECK: begin
                     if (!b.stop_seen) begin
                        abort_transfer();
                     end else begin
                        seq_link = LINK_READY;
                        completed_transfers++;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      c.link_status = seq_link;
   endfunction

   // Offers one beat, waits for it to be taken, and records the prediction.
   task automatic send_beat(input bus_req_type b);
      bus_cmd_type want;
      int          gap;
      req_valid         <= 1'b1;
      req_kind          <= b.kind;
      req_tx_byte       <= b.tx_byte;
      req_slave_address <= b.slave_address;
      req_write_count   <= b.write_count;
      req_read_count    <= b.read_count;
      req_start_seen    <= b.start_seen;
      req_stop_seen     <= b.stop_seen;
      req_nack_seen     <= b.nack_seen;
      req_buffer_full   <= b.buffer_full;
      req_received_byte <= b.received_byte;
      do @(posedge clock); while (req_stall);
      predict_commands(b, want);
      pending_commands.push_back(want);
      beats_sent++;
      gap = sender_idles ? random_idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic bus_req_type random_req();
      bus_req_type b;
      b.kind          = 2'($urandom_range(0, 2));
      b.tx_byte       = 8'($urandom);
      b.slave_address = 8'($urandom);
      b.write_count   = 5'($urandom_range(0, 16));
      b.read_count    = 8'($urandom);
      b.start_seen    = 1'($urandom);
      b.stop_seen     = 1'($urandom);
      b.nack_seen     = 1'($urandom);
      b.buffer_full   = 1'($urandom);
      b.received_byte = 8'($urandom);
      return b;
   endfunction

   task automatic send_load(input logic [7:0] value);
      bus_req_type b;
      b = random_req();
      b.kind    = KIND_LOAD;
      b.tx_byte = value;
      send_beat(b);
   endtask

   task automatic send_start(input logic [7:0] addr, input logic [4:0] wr_cnt,
                             input logic [7:0] rd_cnt);
      bus_req_type b;
      b = random_req();
      b.kind          = KIND_START;
      b.slave_address = addr;
      b.write_count   = wr_cnt;
      b.read_count    = rd_cnt;
      send_beat(b);
   endtask

   task automatic send_event(input logic start, input logic stop, input logic nack,
                             input logic full, input logic [7:0] data);
      bus_req_type b;
      b = random_req();
      b.kind          = KIND_EVENT;
      b.start_seen    = start;
      b.stop_seen     = stop;
      b.nack_seen     = nack;
      b.buffer_full   = full;
      b.received_byte = data;
      send_beat(b);
   endtask

   // Sets the flag the current phase checks to its good value; buffer_full is set 3 times in 4.
   function automatic void shape_event(inout bus_req_type b);
      case (seq_phase)
         SEQ_START, SEQ_RESTART:  b.start_seen  = 1'b1;
         SEQ_WRITE, SEQ_ADDR_ACK: b.nack_seen   = 1'b0;
         SEQ_RECEIVE:             b.buffer_full = ($urandom_range(0, 3) != 0);
         SEQ_STOP_CHECK:          b.stop_seen   = 1'b1;
         default: ;
      endcase
   endfunction

   // One transfer: start, load the bytes to write, then bus events until the
   // link leaves the busy status or the guard runs out. Broken transfers get random flags often.
   task automatic run_transaction(input bit broken);
      bus_req_type b;
      int          wr_cnt;
      int          rd_cnt;
      int          pick;
      int          guard;
      pick   = $urandom_range(0, 19);
      wr_cnt = (pick == 0) ? 16 : $urandom_range(0, 5);
      pick   = $urandom_range(0, 99);
      if (pick < 2)      rd_cnt = $urandom_range(128, 255);
      else if (pick < 8) rd_cnt = $urandom_range(5, 20);
      else               rd_cnt = $urandom_range(0, 4);
      send_start(8'($urandom), 5'(wr_cnt), 8'(rd_cnt));
      repeat (wr_cnt) send_load(8'($urandom));
      guard = 0;
      while (seq_link == LINK_BUSY && guard < 600) begin
         b = random_req();
         if ($urandom_range(0, 29) == 0) begin
            // Stray load or start in mid transfer; a start is ignored here.
            b.kind = $urandom_range(0, 1) ? KIND_LOAD : KIND_START;
         end else begin
            b.kind = KIND_EVENT;
            if (!broken || $urandom_range(0, 3) != 0) shape_event(b);
         end
         send_beat(b);
         guard++;
      end
   endtask

   // Bus events while the link is idle issue no commands.
   task automatic test_idle_events();
      send_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      send_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
   endtask

   // A full write then read transfer, with an early byte in the read preamble,
   // an empty buffer wait and an ignored start while busy.
   task automatic test_write_then_read();
      send_start(8'hFF, 5'd2, 8'd2);
      send_load(8'h00);
      send_load(8'hFF);
      send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
      send_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
      send_event(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
      send_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
      send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
      send_event(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
      send_start(8'h00, 5'd0, 8'd0);
      send_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
      send_event(1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
      send_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
      send_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
   endtask

   // Zero counts, a missing start condition and a NACK on the read address.
   task automatic test_abort_paths();
      send_start(8'h00, 5'd0, 8'd0);
      send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
      send_start(8'h55, 5'd16, 8'd255);
      send_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
      send_start(8'hAA, 5'd0, 8'd1);
      send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
      send_event(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF);
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so
   // the response register fills and the request side stalls.
   task automatic test_response_hold();
      sender_idles     = 1'b0;
      rsp_hold_request = 150;
      repeat (6) send_load(8'($urandom));
      run_transaction(1'b0);
      run_transaction(1'b0);
      sender_idles = 1'b1;
   endtask

   task automatic test_random_traffic();
      bus_req_type b;
      int          pick;
      while (beats_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) sender_idles = !sender_idles;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            // Loads and ignored events between transfers.
            b = random_req();
            if (b.kind == KIND_START) b.kind = KIND_EVENT;
            send_beat(b);
         end else begin
            run_transaction(pick < 3);
         end
      end
   endtask

   // Receiver stall pattern: random stretches of stalls and free cycles, plus
   // a long hold when a test asks for it.
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         stall_left       = rsp_hold_request;
         rsp_hold_request = 0;
         free_left        = 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b0;
         free_left = $urandom_range(10, 60);
      end else begin
         stall_left = random_idle_len();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each accepted response beat with the oldest prediction.
   always @(posedge clock) begin : check_responses
      bus_cmd_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_commands.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            mismatch_count++;
         end else begin
            want = pending_commands.pop_front();
            responses_checked++;
            check_field("send_valid", want.send_valid, rsp_send_valid);
            check_field("send_byte", want.send_byte, rsp_send_byte);
            check_field("repeat_start", want.repeat_start, rsp_repeat_start);
            check_field("stop_request", want.stop_request, rsp_stop_request);
            check_field("receive_enable", want.receive_enable, rsp_receive_enable);
            check_field("ack_send", want.ack_send, rsp_ack_send);
            check_field("ack_is_nack", want.ack_is_nack, rsp_ack_is_nack);
            check_field("rx_valid", want.rx_valid, rsp_rx_valid);
            check_field("rx_byte", want.rx_byte, rsp_rx_byte);
            check_field("link_status", want.link_status, rsp_link_status);
         end
      end
   end

   initial begin
      for (int i = 0; i < 16; i++) seq_tx_bytes[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_idle_events();
      test_write_then_read();
      test_abort_paths();
      test_response_hold();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d request beats and checked %0d response beats.",
               beats_sent, responses_checked);
      $display("Transfers completed %0d, aborted %0d, bytes received %0d.",
               completed_transfers, aborted_transfers, rx_bytes_seen);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: i2c_master_transaction_sequencer.f
design/i2c_seq_pkg.sv
design/i2c_seq_tx_buffer.sv
design/i2c_master_transaction_sequencer.sv
verif/i2c_master_transaction_sequencer_test.sv
